>>> sv/arp_pkg.sv
package arp_pkg;
  localparam int KeyCount = 128;
  localparam int ChunkWidth = 49;
  localparam int TopBits = 30;
  localparam int IdxW = 7;
  localparam int CntW = 8;
  localparam int ItemW = 1 + 2 + ChunkWidth + 1 + 1;
  localparam int QueueDepth = 2;

  localparam logic [2:0] ModeUp = 3'd0;
  localparam logic [2:0] ModeDown = 3'd1;
  localparam logic [2:0] ModeUpDown = 3'd2;
  localparam logic [2:0] ModeDownUp = 3'd3;
  localparam logic [2:0] ModeRandom = 3'd4;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegSteps = 3'd1;
  localparam logic [2:0] RegSeed = 3'd2;
  localparam logic [2:0] RegOctave = 3'd3;
  localparam logic [2:0] RegTrigger = 3'd4;
  localparam logic [2:0] RegPhase = 3'd5;

  typedef struct packed {
    logic                  keys_valid;
    logic [1:0]            chunk_select;
    logic [ChunkWidth-1:0] chunk_bits;
    logic                  trigger_level;
    logic                  reset_level;
  } item_t;

  typedef struct packed {
    logic [6:0] note;
    logic       gate;
    logic       step_pulse;
    logic [6:0] step_number;
  } result_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  steps;
    logic [30:0] seed;
    logic [3:0]  octave;
    logic        trig_conn;
    logic [31:0] phase_inc;
  } cfg_t;
endpackage

>>> sv/clocked_arpeggiator_core.sv
// Each word runs a key scan, then, if a step fires, the pattern step.
// The back end takes a new word only when idle, after its last result is handed to the output register.
// Input queue holds two words; one result word waits in the output register.
// Reset: synchronous active-high rst clears masks, pattern state and registers to defaults.
// The note list has no reset; it is rewritten on every scan before being read.
module clocked_arpeggiator_core #(
  parameter int QueueDepth = arp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        keys_valid,
  input  logic [1:0]  chunk_select,
  input  logic [48:0] chunk_bits,
  input  logic        trigger_level,
  input  logic        reset_level,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  note,
  output logic        gate,
  output logic        step_pulse,
  output logic [6:0]  step_number,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  arp_pkg::cfg_t    cfg;
  arp_pkg::item_t   in_item, q_item;
  arp_pkg::result_t bres, ores;
  logic q_valid, q_take, res_valid, res_take, busy;
  logic cfg_wr;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= '0;
      cfg.steps <= '0;
      cfg.seed <= 31'd1;
      cfg.octave <= '0;
      cfg.trig_conn <= 1'b0;
      cfg.phase_inc <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        arp_pkg::RegMode: cfg.mode <= pwdata[2:0];
        arp_pkg::RegSteps: cfg.steps <= pwdata[7:0];
        arp_pkg::RegSeed: cfg.seed <= pwdata[30:0];
        arp_pkg::RegOctave: cfg.octave <= pwdata[3:0];
        arp_pkg::RegTrigger: cfg.trig_conn <= pwdata[0];
        arp_pkg::RegPhase: cfg.phase_inc <= pwdata;
        default: ;
      endcase
    end
  end

  // read back registers
  always_comb begin
    case (reg_idx)
      arp_pkg::RegMode: prdata = {29'b0, cfg.mode};
      arp_pkg::RegSteps: prdata = {24'b0, cfg.steps};
      arp_pkg::RegSeed: prdata = {1'b0, cfg.seed};
      arp_pkg::RegOctave: prdata = {28'b0, cfg.octave};
      arp_pkg::RegTrigger: prdata = {31'b0, cfg.trig_conn};
      arp_pkg::RegPhase: prdata = cfg.phase_inc;
      default: prdata = '0;
    endcase
  end

  assign in_item = '{keys_valid, chunk_select, chunk_bits, trigger_level, reset_level};

  arp_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  arp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
    .q_take(q_take), .res_valid(res_valid), .res(bres), .res_take(res_take),
    .busy(busy)
  );

  arp_outq u_outq (
    .clk(clk), .rst(rst), .in_valid(res_valid), .in_res(bres), .in_take(res_take),
    .empty(empty), .pop(pop), .out_res(ores)
  );

  assign note = ores.note;
  assign gate = ores.gate;
  assign step_pulse = ores.step_pulse;
  assign step_number = ores.step_number;

  // a pulse is only reported while keys are held
  assert property (@(posedge clk) disable iff (rst) !empty && step_pulse |-> gate)
    else $error("step pulse without gate");
  // back end takes a word only when idle
  assert property (@(posedge clk) disable iff (rst) q_take |-> !busy)
    else $error("queue pop while busy");
  // a result handed over leaves the output nonempty
  assert property (@(posedge clk) disable iff (rst) res_take |=> !empty)
    else $error("result lost");
endmodule

>>> sv/arp_front.sv
module arp_front #(
  parameter int Depth = arp_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  arp_pkg::item_t  in_item,
  output logic            q_valid,
  output arp_pkg::item_t  q_item,
  input  logic            q_take
);
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;

  arp_pkg::item_t mem [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == (PW+1)'(Depth));
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  // write incoming words into the queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule

>>> sv/arp_back.sv
module arp_back (
  input  logic             clk,
  input  logic             rst,
  input  arp_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  arp_pkg::item_t   q_item,
  output logic             q_take,
  output logic             res_valid,
  output arp_pkg::result_t res,
  input  logic             res_take,
  output logic             busy
);
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StScan   = 4'd1;
  localparam logic [3:0] StEdge   = 4'd2;
  localparam logic [3:0] StRead   = 4'd3;
  localparam logic [3:0] StNote   = 4'd4;
  localparam logic [3:0] StRng1   = 4'd5;
  localparam logic [3:0] StRng2   = 4'd6;
  localparam logic [3:0] StRng3   = 4'd7;
  localparam logic [3:0] StMod    = 4'd8;
  localparam logic [3:0] StFinish = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;
  localparam logic [3:0] StFetch  = 4'd11;

  logic [3:0]  state;
  logic [arp_pkg::ChunkWidth-1:0] mask0, mask1, mask2;
  logic [6:0]  note_list [arp_pkg::KeyCount];
  logic [7:0]  key;
  logic [7:0]  count;
  logic [6:0]  play_index;
  logic        direction_down;
  logic [7:0]  clocks;
  logic [31:0] rng_word;
  logic [31:0] phase_acc;
  logic [6:0]  last_note;
  logic [6:0]  last_step;
  logic        clock_was_high;
  logic        reset_was_high;
  logic        pulse;
  logic [6:0]  rd_data;
  logic [31:0] rem;
  logic [5:0]  mod_bit;
  arp_pkg::item_t cur;

  logic [2:0]  eff_mode;
  logic [7:0]  eff_steps;
  logic [31:0] eff_seed;
  logic signed [3:0] eff_oct;
  logic        key_bit;
  logic signed [8:0] midi;
  logic [31:0] rem_sh;
  logic [39:0] rem_try;

  assign eff_mode = (cfg.mode > arp_pkg::ModeRandom) ? arp_pkg::ModeRandom : cfg.mode;
  assign eff_steps = (cfg.steps > 8'd128) ? 8'd128 : cfg.steps;
  assign eff_seed = (cfg.seed == '0) ? 32'd1 : {1'b0, cfg.seed};
  always_comb begin
    eff_oct = $signed(cfg.octave);
    if (eff_oct < -4'sd4) eff_oct = -4'sd4;
    if (eff_oct > 4'sd4) eff_oct = 4'sd4;
  end

  // select the mask bit of the key being scanned
  always_comb begin
    if (key < 8'd49) begin
      key_bit = mask0[key[5:0]];
    end else if (key < 8'd98) begin
      key_bit = mask1[6'(key - 8'd49)];
    end else begin
      key_bit = mask2[6'(key - 8'd98)];
    end
  end

  assign midi = $signed({2'b0, rd_data}) + 9'(eff_oct) * 9'sd12;
  assign rem_sh = rem;
  assign rem_try = {8'b0, rem_sh} - ({32'b0, count} << mod_bit);

  assign q_take = (state == StIdle) && q_valid;
  assign res_valid = (state == StOut);
  assign res.note = last_note;
  assign res.gate = (count != 8'd0);
  assign res.step_pulse = pulse && (count != 8'd0);
  assign res.step_number = last_step;
  assign busy = (state != StIdle);

  // read the note list through a registered port
  always_ff @(posedge clk) begin
    rd_data <= note_list[play_index];
    if (state == StScan && key_bit && key < 8'd128) begin
      note_list[count[6:0]] <= key[6:0];
    end
  end

  // sequence one word: update mask, rescan list, step the pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      mask0 <= '0;
      mask1 <= '0;
      mask2 <= '0;
      count <= '0;
      play_index <= '0;
      direction_down <= 1'b0;
      clocks <= '0;
      rng_word <= 32'd1;
      phase_acc <= '0;
      last_note <= '0;
      last_step <= '0;
      clock_was_high <= 1'b0;
      reset_was_high <= 1'b0;
      pulse <= 1'b0;
      key <= '0;
      rem <= '0;
      mod_bit <= '0;
      cur <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.keys_valid) begin
              case (q_item.chunk_select)
                2'd0: mask0 <= q_item.chunk_bits;
                2'd1: mask1 <= q_item.chunk_bits;
                2'd2: mask2 <= {19'b0, q_item.chunk_bits[arp_pkg::TopBits-1:0]};
                default: ;
              endcase
            end
            key <= '0;
            count <= '0;
            pulse <= 1'b0;
            state <= StScan;
          end
        end
        StScan: begin
          if (key == 8'd128) begin
            if (count == 8'd0) begin
              play_index <= '0;
            end else if ({1'b0, play_index} >= count) begin
              play_index <= 7'(count - 8'd1);
            end
            state <= StEdge;
          end else begin
            if (key_bit) count <= count + 8'd1;
            key <= key + 8'd1;
          end
        end
        StEdge: begin
          logic fire;
          logic restart_edge;
          logic [7:0] clk_now;
          logic [31:0] ph_base;
          logic [32:0] ph_sum;
          fire = 1'b0;
          restart_edge = cur.reset_level && !reset_was_high;
          clk_now = restart_edge ? 8'd0 : clocks;
          ph_base = restart_edge ? 32'd0 : phase_acc;
          ph_sum = {1'b0, ph_base} + {1'b0, cfg.phase_inc};
          reset_was_high <= cur.reset_level;
          if (restart_edge) begin
            play_index <= '0;
            direction_down <= (eff_mode == arp_pkg::ModeDownUp);
            rng_word <= eff_seed;
            clocks <= '0;
          end
          if (cfg.trig_conn) begin
            fire = (count != 8'd0) && cur.trigger_level && !clock_was_high;
            clock_was_high <= cur.trigger_level;
            phase_acc <= ph_base;
          end else begin
            clock_was_high <= 1'b0;
            if (cfg.phase_inc != '0) begin
              if (count != 8'd0 && clk_now == 8'd0) begin
                fire = 1'b1;
                phase_acc <= '0;
              end else begin
                phase_acc <= ph_sum[31:0];
                fire = ph_sum[32] && (count != 8'd0);
              end
            end else begin
              phase_acc <= ph_base;
            end
          end
          pulse <= fire;
          state <= fire ? StRead : StOut;
        end
        StRead: begin
          // step-count restart before playing
          if (eff_steps != 8'd0 && clocks >= eff_steps) begin
            play_index <= '0;
            direction_down <= (eff_mode == arp_pkg::ModeDownUp);
            rng_word <= eff_seed;
            clocks <= '0;
          end
          state <= StFetch;
        end
        StFetch: begin
          // wait for the list entry at the final play_index
          state <= StNote;
        end
        StNote: begin
          // rd_data holds the list entry at play_index, registered in StFetch
          if (midi < 9'sd0) last_note <= 7'd0;
          else if (midi > 9'sd127) last_note <= 7'd127;
          else last_note <= midi[6:0];
          last_step <= (eff_steps != 8'd0) ? clocks[6:0] : play_index;
          if (clocks != 8'd255) clocks <= clocks + 8'd1;
          if (count == 8'd1) begin
            play_index <= '0;
            state <= StOut;
          end else if (eff_mode == arp_pkg::ModeRandom) begin
            state <= StRng1;
          end else begin
            state <= StFinish;
          end
        end
        StRng1: begin
          rng_word <= rng_word ^ (rng_word << 13);
          state <= StRng2;
        end
        StRng2: begin
          rng_word <= rng_word ^ (rng_word >> 17);
          state <= StRng3;
        end
        StRng3: begin
          logic [31:0] x;
          x = rng_word ^ (rng_word << 5);
          if (x == '0) x = 32'd1;
          rng_word <= x;
          rem <= x;
          mod_bit <= 6'd30;
          state <= StMod;
        end
        StMod: begin
          // restoring remainder, one bit per cycle
          if (!rem_try[39]) rem <= rem_try[31:0];
          if (mod_bit == '0) state <= StFinish;
          else mod_bit <= mod_bit - 6'd1;
        end
        StFinish: begin
          case (eff_mode)
            arp_pkg::ModeUp: begin
              play_index <= ({1'b0, play_index} + 8'd1 >= count) ? '0 : play_index + 7'd1;
            end
            arp_pkg::ModeDown: begin
              play_index <= (play_index == '0) ? 7'(count - 8'd1) : play_index - 7'd1;
            end
            arp_pkg::ModeUpDown, arp_pkg::ModeDownUp: begin
              if (!direction_down) begin
                if ({1'b0, play_index} + 8'd1 >= count) begin
                  direction_down <= 1'b1;
                  play_index <= 7'(count - 8'd2);
                end else begin
                  play_index <= play_index + 7'd1;
                end
              end else if (play_index == '0) begin
                direction_down <= 1'b0;
                play_index <= 7'd1;
              end else begin
                play_index <= play_index - 7'd1;
              end
            end
            default: begin
              if (rem[6:0] == play_index) begin
                play_index <= ({1'b0, rem[6:0]} + 8'd1 >= count) ? '0 : rem[6:0] + 7'd1;
              end else begin
                play_index <= rem[6:0];
              end
            end
          endcase
          state <= StOut;
        end
        StOut: begin
          if (res_take) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

>>> sv/arp_outq.sv
module arp_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  arp_pkg::result_t in_res,
  output logic             in_take,
  output logic             empty,
  input  logic             pop,
  output arp_pkg::result_t out_res
);
  logic held;

  assign empty = !held;
  assign in_take = in_valid && (!held || pop);

  // hold one result word until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_take) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) out_res <= in_res;
  end
endmodule

>>> dv/tb_clocked_arpeggiator_core.sv
`timescale 1ns / 100ps

module tb_clocked_arpeggiator_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        keys_valid = 1'b0;
  logic [1:0]  chunk_select = 2'd0;
  logic [48:0] chunk_bits = '0;
  logic        trigger_level = 1'b0;
  logic        reset_level = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  note;
  logic        gate;
  logic        step_pulse;
  logic [6:0]  step_number;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clocked_arpeggiator_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Directed stimulus: either a register write or an input word
  typedef struct {
    bit               is_reg;
    logic [2:0]       reg_idx;
    logic [31:0]      reg_val;
    arp_pkg::item_t   word;
    bit               has_exp;
    arp_pkg::result_t exp;
  } row_t;

  row_t             directed_rows[$];
  arp_pkg::result_t expected_notes[$];
  int      errors = 0;
  int      send_idle = 10;
  int      recv_idle = 61;

  // Arpeggiator shadow: configuration
  logic [2:0]  sh_mode = '0;
  logic [7:0]  sh_steps = '0;
  logic [30:0] sh_seed = 31'd1;
  logic [3:0]  sh_oct = '0;
  logic        sh_trig = 1'b0;
  logic [31:0] sh_pinc = '0;
  // Arpeggiator shadow: pattern state
  logic [48:0] held_mask[3] = '{default: '0};
  logic [6:0]  held_notes[arp_pkg::KeyCount];
  int          held_count = 0;
  int          play_pos = 0;
  bit          going_down = 0;
  int          clocks_run = 0;
  logic [31:0] rng_word = 32'd1;
  logic [31:0] phase_acc = '0;
  logic [6:0]  last_note = '0;
  logic [6:0]  last_step = '0;
  bit          trig_was_high = 0;
  bit          rst_was_high = 0;

  function automatic int play_mode();
    return (sh_mode > arp_pkg::ModeRandom) ? int'(arp_pkg::ModeRandom) : int'(sh_mode);
  endfunction

  function automatic void rewind_play();
    play_pos = 0;
    going_down = (play_mode() == int'(arp_pkg::ModeDownUp));
    rng_word = (sh_seed == 0) ? 32'd1 : {1'b0, sh_seed};
    clocks_run = 0;
  endfunction

  function automatic void advance_index();
    logic [31:0] x;
    int nx;
    if (held_count == 0) return;
    if (held_count == 1) begin
      play_pos = 0;
      return;
    end
    case (play_mode())
      int'(arp_pkg::ModeUp): play_pos = (play_pos + 1) % held_count;
      int'(arp_pkg::ModeDown): play_pos = (play_pos + held_count - 1) % held_count;
      int'(arp_pkg::ModeUpDown), int'(arp_pkg::ModeDownUp): begin
        if (!going_down) begin
          if (play_pos + 1 >= held_count) begin
            going_down = 1;
            play_pos = held_count - 2;
          end else begin
            play_pos++;
          end
        end else begin
          if (play_pos == 0) begin
            going_down = 0;
            play_pos = 1;
          end else begin
            play_pos--;
          end
        end
      end
      default: begin
        x = rng_word;
        x ^= x << 13;
        x ^= x >> 17;
        x ^= x << 5;
        rng_word = (x == 0) ? 32'd1 : x;
        nx = int'(rng_word % held_count);
        if (nx == play_pos) nx = (nx + 1) % held_count;
        play_pos = nx;
      end
    endcase
  endfunction

  function automatic void fire_step();
    int steps;
    int oct;
    int midi;
    steps = (sh_steps > 8'd128) ? 128 : int'(sh_steps);
    if (steps > 0 && clocks_run >= steps) rewind_play();
    oct = int'($signed(sh_oct));
    if (oct < -4) oct = -4;
    if (oct > 4) oct = 4;
    midi = int'(held_notes[play_pos & 127]) + oct * 12;
    if (midi < 0) midi = 0;
    if (midi > 127) midi = 127;
    last_note = midi[6:0];
    last_step = (steps > 0) ? clocks_run[6:0] : play_pos[6:0];
    if (clocks_run < 255) clocks_run++;
    advance_index();
  endfunction

  // Compute the result word that one accepted input word causes
  function automatic arp_pkg::result_t arp_predict(arp_pkg::item_t w);
    arp_pkg::result_t r;
    bit fired;
    int c;
    int off;
    logic [32:0] sum;
    fired = 0;
    if (w.keys_valid) begin
      case (w.chunk_select)
        2'd0: held_mask[0] = w.chunk_bits;
        2'd1: held_mask[1] = w.chunk_bits;
        2'd2: held_mask[2] = w.chunk_bits & ((49'd1 << arp_pkg::TopBits) - 49'd1);
        default: ;
      endcase
    end
    // Rebuild the ascending note list
    held_count = 0;
    for (int k = 0; k < arp_pkg::KeyCount; k++) begin
      c = (k >= 98) ? 2 : (k >= 49) ? 1 : 0;
      off = k - c * arp_pkg::ChunkWidth;
      if (held_mask[c][off]) begin
        held_notes[held_count] = k[6:0];
        held_count++;
      end
    end
    if (held_count == 0) play_pos = 0;
    else if (play_pos >= held_count) play_pos = held_count - 1;
    if (w.reset_level && !rst_was_high) begin
      rewind_play();
      phase_acc = '0;
    end
    rst_was_high = w.reset_level;
    if (sh_trig) begin
      if (held_count > 0 && w.trigger_level && !trig_was_high) begin
        fire_step();
        fired = 1;
      end
      trig_was_high = w.trigger_level;
    end else begin
      if (sh_pinc != 0) begin
        if (held_count > 0 && clocks_run == 0) begin
          fire_step();
          fired = 1;
          phase_acc = '0;
        end else begin
          sum = {1'b0, phase_acc} + {1'b0, sh_pinc};
          phase_acc = sum[31:0];
          if (sum[32] && held_count > 0) begin
            fire_step();
            fired = 1;
          end
        end
      end
      trig_was_high = 0;
    end
    r.note = last_note;
    r.gate = (held_count > 0);
    r.step_pulse = (held_count > 0) && fired;
    r.step_number = last_step;
    return r;
  endfunction

  // Check each popped result word against the oldest expectation
  always @(posedge clk) begin
    arp_pkg::result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_notes.size() == 0) begin
          $error("unexpected result word note=%0d", note);
          errors++;
        end else begin
          want = expected_notes.pop_front();
          if (note !== want.note) begin
            $error("note expected %0d actual %0d", want.note, note);
            errors++;
          end
          if (gate !== want.gate) begin
            $error("gate expected %0d actual %0d", want.gate, gate);
            errors++;
          end
          if (step_pulse !== want.step_pulse) begin
            $error("step_pulse expected %0d actual %0d", want.step_pulse, step_pulse);
            errors++;
          end
          if (step_number !== want.step_number) begin
            $error("step_number expected %0d actual %0d", want.step_number, step_number);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one word; push stays high afterwards so words can go back to back
  task automatic send_word(arp_pkg::item_t w, bit has_exp, arp_pkg::result_t exp);
    arp_pkg::result_t r;
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    push <= 1'b1;
    keys_valid <= w.keys_valid;
    chunk_select <= w.chunk_select;
    chunk_bits <= w.chunk_bits;
    trigger_level <= w.trigger_level;
    reset_level <= w.reset_level;
    @(posedge clk);
    while (full) @(posedge clk);
    r = arp_predict(w);
    expected_notes.push_back(has_exp ? exp : r);
  endtask

  // Drain, then write one register over APB
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    push <= 1'b0;
    @(posedge clk);
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      arp_pkg::RegMode: sh_mode = val[2:0];
      arp_pkg::RegSteps: sh_steps = val[7:0];
      arp_pkg::RegSeed: sh_seed = val[30:0];
      arp_pkg::RegOctave: sh_oct = val[3:0];
      arp_pkg::RegTrigger: sh_trig = val[0];
      arp_pkg::RegPhase: sh_pinc = val;
      default: ;
    endcase
  endtask

  function automatic void add_word(logic kv, logic [1:0] sel, logic [48:0] bits,
                                   logic trig, logic rl, bit has_exp,
                                   arp_pkg::result_t exp);
    row_t r;
    r.is_reg = 0;
    r.word = '{kv, sel, bits, trig, rl};
    r.has_exp = has_exp;
    r.exp = exp;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
    row_t r;
    r.is_reg = 1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.has_exp = 0;
    directed_rows.push_back(r);
  endfunction

  function automatic arp_pkg::item_t random_word();
    arp_pkg::item_t w;
    w.keys_valid = ($urandom_range(99) < 60);
    w.chunk_select = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: w.chunk_bits = 49'({$urandom, $urandom});
      1: w.chunk_bits = (49'd1 << $urandom_range(48)) | (49'd1 << $urandom_range(48));
      2: w.chunk_bits = '0;
      default: w.chunk_bits = '1;
    endcase
    w.trigger_level = 1'($urandom_range(1));
    w.reset_level = ($urandom_range(99) < 5);
    return w;
  endfunction

  localparam int Phases = 7;
  localparam int PerPhase = 150;

  logic [2:0]  ph_mode[Phases]  = '{0, 1, 2, 3, 4, 7, 4};
  logic [31:0] ph_steps[Phases] = '{0, 1, 128, 5, 255, 0, 3};
  logic [31:0] ph_seed[Phases]  = '{0, 1, 32'h7FFF_FFFF, 32'h1234_5678, 32'h5A5A_A5A5,
                                    32'h2AAA_AAAA, 32'h5555_5555};
  logic [3:0]  ph_oct[Phases]   = '{0, 7, 8, 4, 12, 1, 15};
  logic        ph_trig[Phases]  = '{0, 1, 0, 1, 1, 0, 1};
  logic [31:0] ph_pinc[Phases]  = '{32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h9E37_79B9, 0,
                                    32'h4000_0000, 32'h0000_0001};

  initial begin
    arp_pkg::result_t zero_res;
    int n;
    zero_res = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: nothing held, internal clock stopped
    add_word(0, 0, '0, 0, 0, 1, zero_res);
    add_word(1, 3, '1, 0, 0, 1, zero_res);                 // chunk select three is ignored
    add_word(1, 0, 49'd1, 0, 0, 1, '{7'd0, 1'b1, 1'b0, 7'd0});
    // External trigger plays the lowest key at once
    add_reg(arp_pkg::RegTrigger, 32'd1);
    add_word(1, 0, 49'd1, 1, 0, 1, '{7'd0, 1'b1, 1'b1, 7'd0});
    add_word(1, 2, '1, 0, 0, 0, zero_res);                 // top chunk drops bits 30..48
    add_word(1, 1, 49'h1_0000_0000_0001, 1, 0, 0, zero_res);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 1, 0, 0, zero_res);
    add_reg(arp_pkg::RegOctave, 32'd4);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 1, 1, 0, zero_res);                 // reset edge restarts the pattern
    add_reg(arp_pkg::RegOctave, 32'h8);
    add_reg(arp_pkg::RegMode, 32'(arp_pkg::ModeRandom));
    add_reg(arp_pkg::RegSeed, 32'd0);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 1, 0, 0, zero_res);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 1, 0, 0, zero_res);
    // Release all keys: gate drops, note and step hold
    add_word(1, 0, '0, 0, 0, 0, zero_res);
    add_word(1, 1, '0, 1, 0, 0, zero_res);
    add_word(1, 2, '0, 1, 0, 0, zero_res);
    // Internal clock at its largest phase increment
    add_reg(arp_pkg::RegTrigger, 32'd0);
    add_reg(arp_pkg::RegPhase, 32'hFFFF_FFFF);
    add_reg(arp_pkg::RegSteps, 32'd2);
    add_word(1, 0, 49'h0_0000_0000_0888, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 0, 0, 0, zero_res);
    add_word(0, 0, '0, 0, 0, 0, zero_res);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_word(directed_rows[i].word, directed_rows[i].has_exp, directed_rows[i].exp);
    end

    // Random phases over several register settings
    n = 0;
    for (int p = 0; p < Phases; p++) begin
      write_reg(arp_pkg::RegMode, {29'd0, ph_mode[p]});
      write_reg(arp_pkg::RegSteps, ph_steps[p]);
      write_reg(arp_pkg::RegSeed, ph_seed[p]);
      write_reg(arp_pkg::RegOctave, {28'd0, ph_oct[p]});
      write_reg(arp_pkg::RegTrigger, {31'd0, ph_trig[p]});
      write_reg(arp_pkg::RegPhase, ph_pinc[p]);
      for (int i = 0; i < PerPhase; i++) begin
        if (n < 350) begin
          send_idle = 10;
          recv_idle = 61;
        end else if (n < 700) begin
          send_idle = 61;
          recv_idle = 10;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        send_word(random_word(), 0, zero_res);
        n++;
      end
    end

    // Drain and let the block settle
    push <= 1'b0;
    @(posedge clk);
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_notes.size() == 0) begin
      $display("[clocked_arpeggiator_core] OK");
    end else begin
      $display("[clocked_arpeggiator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[clocked_arpeggiator_core] ERROR");
    $finish;
  end
endmodule

>>> sim.f
sv/arp_pkg.sv
sv/arp_front.sv
sv/arp_back.sv
sv/arp_outq.sv
sv/clocked_arpeggiator_core.sv
dv/tb_clocked_arpeggiator_core.sv
